@@ rtl/sha256_pkg.sv @@
// SHA-256 hasher package: payload structs, controller state enum, constants.
// Used by sha256_ctrl, sha256_dp and the top level.
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic       wr_byte;     // write input byte at fill position
        logic       wr_pad;      // write padding byte at pad position
        logic       wr_len;      // write length byte
        logic       load;        // copy store into schedule, chain into a..h
        logic       round;       // run one round
        logic       fold;        // add working words to chain
        logic       reinit;      // chain back to initial values, count to zero
        logic       emit_shift;  // next digest word
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic       store_full;  // fill position 63 written by this byte
        logic       pad_wrap;    // padding needs a second block
        logic [5:0] pad_pos;
        logic       round_last;
    } t_stat;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ rtl/sha256_dp.sv @@
// SHA-256 datapath: block store, byte count, schedule window, round unit, chain.
// Depends on sha256_pkg; driven by sha256_ctrl commands.
module sha256_dp
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_byte,
    input  logic [2:0]  i_len_idx,
    input  logic        i_pad_second,
    output t_stat       o_stat,
    output logic [31:0] o_word
);

    // block store kept as 16 big-endian words, written one byte lane at a time
    logic [31:0] r_store [16];
    logic [60:0] r_count;
    logic [5:0]  r_pad_pos;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [5:0]  r_round;
    logic [2:0]  r_emit;

    logic [5:0]  fill_pos;
    logic [63:0] bits;
    logic [31:0] w_new, w_cur, t1, t2, s0, s1;

    assign fill_pos = r_count[5:0];
    assign bits     = {r_count, 3'b000};

    always_comb begin
        s0    = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        w_cur = (r_round < 6'd16) ? r_w[0] : w_new;
        t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + K_ROUND[r_round] + w_cur;
        t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // pad byte: 0x80 at the first pad position, zeros after
    logic [7:0] pad_val;
    assign pad_val = (!i_pad_second && r_pad_pos == fill_pos) ? PAD_BYTE : 8'h00;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte)
            r_store[fill_pos[5:2]][{~fill_pos[1:0], 3'b000} +: 8] <= i_byte;
        if (i_cmd.wr_pad)
            r_store[r_pad_pos[5:2]][{~r_pad_pos[1:0], 3'b000} +: 8] <= pad_val;
        if (i_cmd.wr_len)
            r_store[LEN_POS[5:2] + {3'b000, i_len_idx[2]}][{~i_len_idx[1:0], 3'b000} +: 8]
                <= bits[{~i_len_idx, 3'b000} +: 8];
        if (i_cmd.load) begin
            for (int i = 0; i < 16; i++) r_w[i] <= r_store[i];
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_cmd.round) begin
            // window rolls: r_w[0] is the word for rounds 0-15; later rounds use w_new
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_cur;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    // window after 16 rounds holds w[r-16..r-1]; indexes above match that
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_round   <= '0;
            r_emit    <= '0;
            r_pad_pos <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
        end else begin
            if (i_cmd.wr_byte) r_count <= r_count + 61'd1;
            // pad position follows the next fill position until padding starts,
            // and holds across the compression of a wrapped block
            if (i_cmd.wr_pad)      r_pad_pos <= r_pad_pos + 6'd1;
            else if (i_cmd.reinit) r_pad_pos <= 6'd0;
            else if (!i_cmd.wr_len && !i_cmd.load && !i_cmd.round && !i_cmd.fold)
                r_pad_pos <= fill_pos + {5'b00000, i_cmd.wr_byte};
            if (i_cmd.round) r_round <= r_round + 6'd1;
            if (i_cmd.fold)
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            if (i_cmd.emit_shift) r_emit <= r_emit + 3'd1;
            if (i_cmd.reinit) begin
                r_count <= '0;
                r_emit  <= '0;
                for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
            end
        end
    end

    assign o_stat.store_full = (fill_pos == 6'd63);
    assign o_stat.pad_wrap   = (fill_pos > 6'd55);
    assign o_stat.pad_pos    = r_pad_pos;
    assign o_stat.round_last = (r_round == 6'd63);
    assign o_word            = r_h[r_emit];

endmodule

@@ rtl/sha256_ctrl.sv @@
// SHA-256 controller: sequences byte fill, padding, length, rounds and digest output.
// Depends on sha256_pkg; commands sha256_dp.
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_in_item   i_item,
    output logic       o_stall,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic [2:0] o_len_idx,
    output logic       o_pad_second,
    output logic       o_valid,
    output logic [2:0] o_index,
    input  logic       i_stall
);

    t_state     r_state, n_state;
    logic       r_final, n_final;    // message ends after this compression
    logic       r_second, n_second;  // padding block after a wrapped one
    logic       r_lenblk, n_lenblk;  // current compression is the length block
    logic [2:0] r_cnt, n_cnt;
    logic       accept;

    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state  = r_state;
        n_final  = r_final;
        n_second = r_second;
        n_lenblk = r_lenblk;
        n_cnt    = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_final  = i_item.end_of_message;
                    n_second = 1'b0;
                    n_lenblk = 1'b0;
                    if (i_item.has_byte && i_stat.store_full) n_state = ST_LOAD;
                    else if (i_item.end_of_message)           n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                // pad runs from fill position up to 55, or to 63 if wrapping
                if (!r_second && i_stat.pad_wrap) begin
                    if (i_stat.pad_pos == 6'd63) n_state = ST_LOAD;
                end else if (i_stat.pad_pos == 6'd55) begin
                    n_state = ST_LEN;
                    n_cnt   = '0;
                end
            end
            ST_LEN: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    n_state  = ST_LOAD;
                    n_lenblk = 1'b1;
                end
            end
            ST_LOAD:  n_state = ST_ROUND;
            ST_ROUND: if (i_stat.round_last) n_state = ST_FOLD;
            ST_FOLD: begin
                if (!r_final)     n_state = ST_IDLE;
                else if (r_lenblk) begin
                    n_state = ST_EMIT;
                    n_cnt   = '0;
                end else begin
                    n_state  = ST_PAD;
                    n_second = r_second || i_stat.pad_wrap;
                end
            end
            ST_EMIT: begin
                if (!i_stall) begin
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd7) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_len_idx    = r_cnt;
        o_pad_second = r_second;
        o_valid      = 1'b0;
        o_index      = r_cnt;
        unique case (r_state)
            ST_IDLE:  o_cmd.wr_byte = accept && i_item.has_byte;
            ST_PAD:   o_cmd.wr_pad  = 1'b1;
            ST_LEN:   o_cmd.wr_len  = 1'b1;
            ST_LOAD:  o_cmd.load    = 1'b1;
            ST_ROUND: o_cmd.round   = 1'b1;
            ST_FOLD:  o_cmd.fold    = 1'b1;
            ST_EMIT: begin
                o_valid          = 1'b1;
                o_cmd.emit_shift = !i_stall && (r_cnt != 3'd7);
                o_cmd.reinit     = !i_stall && (r_cnt == 3'd7);
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_final  <= 1'b0;
            r_second <= 1'b0;
            r_lenblk <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_final  <= n_final;
            r_second <= n_second;
            r_lenblk <= n_lenblk;
            r_cnt    <= n_cnt;
        end
    end

endmodule

@@ rtl/sha256_message_hasher_core.sv @@
// SHA-256 hasher top level: joins sha256_ctrl and sha256_dp.
// Depends on sha256_pkg.
//
// Input channel i_valid/o_stall carries one item: a message byte with
// has_byte, and end_of_message on the final item. Output channel
// o_valid/i_stall carries the eight digest words, word 0 first, the eighth
// flagged last_word.
// A byte that does not complete a 64-byte block leaves the input ready for the
// next item. A byte that fills the block holds the input through load, 64
// rounds of the single round unit and fold. The final item adds padding writes
// (up to 64), eight length writes and one or two compressions, then the eight
// digest words, each held while the receiver stalls.
// Reset (synchronous, active low) restores the initial hash values, clears
// the byte count and returns to idle. While the receiver stalls, the current
// digest word holds and no new item is taken.
module sha256_message_hasher_core
    import sha256_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);

    t_cmd        cmd;
    t_stat       stat;
    logic [2:0]  len_idx, idx;
    logic        pad_second;
    logic [31:0] word;

    sha256_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .i_item, .o_stall,
        .i_stat(stat), .o_cmd(cmd), .o_len_idx(len_idx),
        .o_pad_second(pad_second), .o_valid, .o_index(idx), .i_stall
    );

    sha256_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_byte(i_item.data_byte),
        .i_len_idx(len_idx), .i_pad_second(pad_second),
        .o_stat(stat), .o_word(word)
    );

    assign o_item.digest_word = word;
    assign o_item.word_index  = idx;
    assign o_item.last_word   = (idx == 3'd7);

endmodule
